/* hdl/pid_temperature_pwm_controller_macros.svh */
// Assertion macros shared by the controller modules.
`ifndef PID_TEMPERATURE_PWM_CONTROLLER_MACROS_SVH
`define PID_TEMPERATURE_PWM_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low.
`define PTPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, masked while rst_n is low.
`define PTPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ptpc_pkg.sv */
// Shared types, constants and microcode table of the PID temperature controller.
`timescale 1ns / 1ps
`default_nettype none

package ptpc_pkg;

  // Field and register widths
  localparam int SENSOR_W     = 16;
  localparam int SENSOR_SHIFT = 4;
  localparam int TEMP_W       = 12;
  localparam int PCT_W        = 7;
  localparam int COUNT_W      = 14;
  localparam int GAIN_W       = 32;
  localparam int ILIM_W       = 15;
  localparam int CFG_IDX_W    = 3;

  // Datapath widths
  localparam int ERR_W        = TEMP_W + 1;
  localparam int INTEG_W      = ILIM_W + 2;
  localparam int DERIV_W      = ERR_W + 1;
  localparam int MULB_W       = INTEG_W + 1;
  localparam int PROD_W       = GAIN_W + MULB_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int FRAC_SHIFT   = 20;
  localparam int PCT_MAX      = 100;

  localparam int DUTY_FULL_SCALE_DEF = 8192;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = CFG_IDX_W'(4);

  // Reset values
  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(6553600);
  localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = GAIN_W'(3277);
  localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = GAIN_W'(0);
  localparam logic [ILIM_W-1:0]        INTEG_LIM_RST  = ILIM_W'(1600);
  localparam logic [PCT_W-1:0]         OUT_LIM_RST    = PCT_W'(100);

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic [ILIM_W-1:0]        integral_limit;
    logic [PCT_W-1:0]         output_limit;
  } cfg_t;

  // Microcode fields
  typedef enum logic [1:0] {
    JC_NONE,
    JC_IN,
    JC_OUT
  } jump_t;

  typedef enum logic [1:0] {
    GS_PROP,
    GS_INTEG,
    GS_DERIV
  } gain_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    jump_t     jc;
    gain_sel_t mul_sel;
    acc_op_t   acc_op;
    logic      integ_en;
    logic      mul_en;
    logic      pct_en;
    logic      scale_en;
    logic      out_en;
    logic      last;
  } ctrl_t;

  // Handshake status fed back to the sequencer
  typedef struct packed {
    logic in_fire;
    logic out_free;
  } stat_t;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_WAIT  = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_INTEG = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_MULP  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_MULI  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_MULD  = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_PCT   = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_SCALE = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_OUT   = STEP_W'(7);

  localparam ctrl_t CTRL_NOP = '{
    jc:       JC_NONE,
    mul_sel:  GS_PROP,
    acc_op:   ACC_HOLD,
    integ_en: 1'b0,
    mul_en:   1'b0,
    pct_en:   1'b0,
    scale_en: 1'b0,
    out_en:   1'b0,
    last:     1'b0
  };

  // Control program: one word per step
  function automatic ctrl_t ucode_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = CTRL_NOP;
    case (step)
      STEP_WAIT: begin
        w.jc = JC_IN;
      end
      STEP_INTEG: begin
        w.integ_en = 1'b1;
      end
      STEP_MULP: begin
        w.mul_sel = GS_PROP;
        w.mul_en  = 1'b1;
      end
      STEP_MULI: begin
        w.mul_sel = GS_INTEG;
        w.mul_en  = 1'b1;
        w.acc_op  = ACC_LOAD;
      end
      STEP_MULD: begin
        w.mul_sel = GS_DERIV;
        w.mul_en  = 1'b1;
        w.acc_op  = ACC_ADD;
      end
      STEP_PCT: begin
        w.pct_en = 1'b1;
      end
      STEP_SCALE: begin
        w.scale_en = 1'b1;
      end
      STEP_OUT: begin
        w.out_en = 1'b1;
        w.jc     = JC_OUT;
        w.last   = 1'b1;
      end
      default: begin
        w = CTRL_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/ptpc_in_if.sv */
// Input channel: raw sensor word and setpoint.
`timescale 1ns / 1ps
`default_nettype none

interface ptpc_in_if;
  import ptpc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [SENSOR_W-1:0]      sensor_word;
  logic signed [TEMP_W-1:0] target_temp;

  modport source (output valid, output sensor_word, output target_temp, input ready);
  modport sink (input valid, input sensor_word, input target_temp, output ready);
endinterface

`default_nettype wire

/* hdl/ptpc_out_if.sv */
// Result channel: decoded temperature, duty percent and PWM count.
`timescale 1ns / 1ps
`default_nettype none

interface ptpc_out_if;
  import ptpc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] measured_temp;
  logic [PCT_W-1:0]         duty_percent;
  logic [COUNT_W-1:0]       duty_count;

  modport source (output valid, output measured_temp, output duty_percent,
                  output duty_count, input ready);
  modport sink (input valid, input measured_temp, input duty_percent,
                input duty_count, output ready);
endinterface

`default_nettype wire

/* hdl/ptpc_seq.sv */
// Microcode sequencer: step counter, control store lookup and wait jumps.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_temperature_pwm_controller_macros.svh"

module ptpc_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  ptpc_pkg::stat_t stat,
  output ptpc_pkg::ctrl_t ctrl
);
  import ptpc_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              hold;

  // Current control word
  assign ctrl = ucode_word(step_r);

  // Wait jumps hold the step until the handshake completes
  always_comb begin
    case (ctrl.jc)
      JC_IN:   hold = !stat.in_fire;
      JC_OUT:  hold = !stat.out_free;
      default: hold = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_nxt = step_r;
    end else if (ctrl.last) begin
      step_nxt = STEP_WAIT;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  `PTPC_ASSERT_NEXT(a_fire_starts, stat.in_fire, step_r == STEP_INTEG, "accepted item did not start")
  `PTPC_ASSERT_NEXT(a_out_hold, (ctrl.jc == JC_OUT) && !stat.out_free, $stable(step_r), "step moved while output busy")
  `PTPC_ASSERT_NEXT(a_wrap, ctrl.last && stat.out_free, step_r == STEP_WAIT, "program did not wrap")

endmodule

`default_nettype wire

/* hdl/ptpc_datapath.sv */
// PID datapath: error, clamped integral, derivative, shared multiplier, duty scaling.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_temperature_pwm_controller_macros.svh"

module ptpc_datapath #(
  parameter int DUTY_FULL_SCALE = ptpc_pkg::DUTY_FULL_SCALE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ptpc_pkg::ctrl_t                    ctrl,
  input  ptpc_pkg::cfg_t                     cfg,
  input  logic                               gain_clear,
  input  logic                               in_fire,
  input  logic [ptpc_pkg::SENSOR_W-1:0]      sensor_word,
  input  logic signed [ptpc_pkg::TEMP_W-1:0] target_temp,
  input  logic                               out_ready,
  output logic                               out_free,
  output logic                               out_valid,
  output logic signed [ptpc_pkg::TEMP_W-1:0] measured_temp,
  output logic [ptpc_pkg::PCT_W-1:0]         duty_percent,
  output logic [ptpc_pkg::COUNT_W-1:0]       duty_count
);
  import ptpc_pkg::*;

  // Division by 100 as a reciprocal multiply, exact for every scaled value
  localparam int SCALED_W  = $clog2(DUTY_FULL_SCALE * PCT_MAX + 1);
  localparam int DIV_SHIFT = SCALED_W + $clog2(PCT_MAX);
  localparam int RECIP_W   = DIV_SHIFT - $clog2(PCT_MAX) + 1;
  localparam int QUOT_W    = SCALED_W + RECIP_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << DIV_SHIFT) + 64'(PCT_MAX - 1)) / 64'(PCT_MAX);
  localparam logic [RECIP_W-1:0]  DIV_RECIP  = RECIP_W'(RECIP_WIDE);
  localparam logic [SCALED_W-1:0] FULL_SCALE = SCALED_W'(DUTY_FULL_SCALE);
  localparam int PQ_W = ACC_W - FRAC_SHIFT;

  // Registers
  logic signed [TEMP_W-1:0]  meas_r,   meas_nxt;
  logic signed [ERR_W-1:0]   err_r,    err_nxt;
  logic signed [INTEG_W-1:0] integ_r,  integ_nxt;
  logic signed [ERR_W-1:0]   prev_r,   prev_nxt;
  logic signed [DERIV_W-1:0] deriv_r,  deriv_nxt;
  logic signed [PROD_W-1:0]  prod_r,   prod_nxt;
  logic signed [ACC_W-1:0]   acc_r,    acc_nxt;
  logic [PCT_W-1:0]          pct_r,    pct_nxt;
  logic [SCALED_W-1:0]       scaled_r, scaled_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic signed [TEMP_W-1:0]  omeas_r,  omeas_nxt;
  logic [PCT_W-1:0]          opct_r,   opct_nxt;
  logic [COUNT_W-1:0]        ocount_r, ocount_nxt;

  // Combinational terms
  logic signed [TEMP_W-1:0]  meas_in;
  logic signed [ERR_W-1:0]   err_in;
  logic signed [INTEG_W-1:0] integ_sum;
  logic signed [INTEG_W-1:0] ilim;
  logic signed [INTEG_W-1:0] neg_ilim;
  logic signed [INTEG_W-1:0] integ_clamp;
  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [MULB_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]   pid_sum;
  logic [PCT_W-1:0]          out_lim;
  logic [PQ_W-1:0]           pct_q;
  logic                      sum_pos;
  logic [PCT_W-1:0]          pct_in;
  logic [QUOT_W-1:0]         quot;

  // Decode and error
  assign meas_in = $signed(sensor_word[SENSOR_W-1:SENSOR_SHIFT]);
  assign err_in  = ERR_W'(target_temp) - ERR_W'(meas_in);

  // Integral with symmetric clamp
  assign integ_sum = integ_r + INTEG_W'(err_r);
  assign ilim      = $signed(INTEG_W'(cfg.integral_limit));
  assign neg_ilim  = -ilim;

  always_comb begin
    if (integ_sum <= neg_ilim) begin
      integ_clamp = neg_ilim;
    end else if (integ_sum >= ilim) begin
      integ_clamp = ilim;
    end else begin
      integ_clamp = integ_sum;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    case (ctrl.mul_sel)
      GS_INTEG: begin
        mul_a = cfg.integ_gain;
        mul_b = MULB_W'(integ_r);
      end
      GS_DERIV: begin
        mul_a = cfg.deriv_gain;
        mul_b = MULB_W'(deriv_r);
      end
      default: begin
        mul_a = cfg.prop_gain;
        mul_b = MULB_W'(err_r);
      end
    endcase
  end

  // Percent: final accumulate, truncate, clamp to 0..min(output limit, 100)
  assign pid_sum = acc_r + ACC_W'(prod_r);
  assign out_lim = (cfg.output_limit > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : cfg.output_limit;
  assign pct_q   = pid_sum[ACC_W-1:FRAC_SHIFT];
  assign sum_pos = !pid_sum[ACC_W-1] && (pid_sum != '0);

  always_comb begin
    if (!sum_pos) begin
      pct_in = '0;
    end else if (pct_q >= PQ_W'(out_lim)) begin
      pct_in = out_lim;
    end else begin
      pct_in = pct_q[PCT_W-1:0];
    end
  end

  // Count = scaled / 100 via reciprocal
  assign quot = QUOT_W'(scaled_r) * QUOT_W'(DIV_RECIP);

  assign out_free = !ovalid_r || out_ready;

  // Next-state logic
  always_comb begin
    meas_nxt   = meas_r;
    err_nxt    = err_r;
    integ_nxt  = integ_r;
    prev_nxt   = prev_r;
    deriv_nxt  = deriv_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    pct_nxt    = pct_r;
    scaled_nxt = scaled_r;
    omeas_nxt  = omeas_r;
    opct_nxt   = opct_r;
    ocount_nxt = ocount_r;
    ovalid_nxt = ovalid_r && !out_ready;

    if (in_fire) begin
      meas_nxt = meas_in;
      err_nxt  = err_in;
    end
    if (ctrl.integ_en) begin
      integ_nxt = integ_clamp;
      deriv_nxt = DERIV_W'(err_r) - DERIV_W'(prev_r);
      prev_nxt  = err_r;
    end
    if (ctrl.mul_en) begin
      prod_nxt = mul_a * mul_b;
    end
    case (ctrl.acc_op)
      ACC_LOAD: acc_nxt = ACC_W'(prod_r);
      ACC_ADD:  acc_nxt = pid_sum;
      default:  acc_nxt = acc_r;
    endcase
    if (ctrl.pct_en) begin
      pct_nxt = pct_in;
    end
    if (ctrl.scale_en) begin
      scaled_nxt = SCALED_W'(FULL_SCALE * SCALED_W'(pct_r));
    end
    if (ctrl.out_en && out_free) begin
      ovalid_nxt = 1'b1;
      omeas_nxt  = meas_r;
      opct_nxt   = pct_r;
      ocount_nxt = COUNT_W'(quot >> DIV_SHIFT);
    end
    if (gain_clear) begin
      integ_nxt = '0;
      prev_nxt  = '0;
    end
  end

  // Control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      integ_r  <= '0;
      prev_r   <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      integ_r  <= integ_nxt;
      prev_r   <= prev_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    meas_r   <= meas_nxt;
    err_r    <= err_nxt;
    deriv_r  <= deriv_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    pct_r    <= pct_nxt;
    scaled_r <= scaled_nxt;
    omeas_r  <= omeas_nxt;
    opct_r   <= opct_nxt;
    ocount_r <= ocount_nxt;
  end

  assign out_valid     = ovalid_r;
  assign measured_temp = omeas_r;
  assign duty_percent  = opct_r;
  assign duty_count    = ocount_r;

  `PTPC_ASSERT_NEXT(a_integ_bound, ctrl.integ_en && !gain_clear, (integ_r <= $past(ilim)) && (integ_r >= $past(neg_ilim)), "integral outside clamp")
  `PTPC_ASSERT_NEXT(a_gain_clear, gain_clear, (integ_r == '0) && (prev_r == '0), "gain write did not clear state")
  `PTPC_ASSERT_NOW(a_pct_range, ovalid_r, opct_r <= PCT_W'(PCT_MAX), "duty percent above full")

endmodule

`default_nettype wire

/* hdl/pid_temperature_pwm_controller.sv */
// Top level of the PID temperature controller with PWM duty output.
//
// Usage:
//   in_ch carries one raw sensor word (bits 15..4 are the signed temperature in
//   sixteenths of a degree) and a setpoint; a transfer is valid && ready.
//   out_ch returns one result per item: decoded temperature, duty percent
//   clamped to 0..min(output_limit,100), PWM compare count full_scale*pct/100.
//   cfg_we/cfg_index/cfg_wdata write the five registers: 0 prop gain,
//   1 integ gain, 2 deriv gain (Q16.16), 3 integral limit, 4 output limit.
//   Writing any gain clears the integral and the previous error. Write only
//   while no item is in flight.
// Timing:
//   A microcoded sequencer runs an 8-step program per item, one shared
//   32x18 multiplier handling the three PID products in turn. The result is
//   registered on the last step; a new input is taken only on the wait step.
//   The result sits in an output register, so the next item is taken while it
//   waits; if the receiver stalls long enough the program holds on its last
//   step until the output register frees up.
// Reset:
//   rst_n (synchronous, active low) restores register defaults, clears the
//   integral, previous error and output valid. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pid_temperature_pwm_controller #(
  parameter int DUTY_FULL_SCALE = ptpc_pkg::DUTY_FULL_SCALE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ptpc_in_if.sink                          in_ch,
  ptpc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [ptpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptpc_pkg::GAIN_W-1:0]      cfg_wdata
);
  import ptpc_pkg::*;

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  gain_clear;
  ctrl_t ctrl;
  stat_t stat;
  logic  out_free;

  // Configuration register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:   cfg_nxt.prop_gain      = $signed(cfg_wdata);
        REG_INTEG_GAIN:  cfg_nxt.integ_gain     = $signed(cfg_wdata);
        REG_DERIV_GAIN:  cfg_nxt.deriv_gain     = $signed(cfg_wdata);
        REG_INTEG_LIMIT: cfg_nxt.integral_limit = cfg_wdata[ILIM_W-1:0];
        REG_OUT_LIMIT:   cfg_nxt.output_limit   = cfg_wdata[PCT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  assign gain_clear = cfg_we &&
    (cfg_index inside {REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain      <= PROP_GAIN_RST;
      cfg_r.integ_gain     <= INTEG_GAIN_RST;
      cfg_r.deriv_gain     <= DERIV_GAIN_RST;
      cfg_r.integral_limit <= INTEG_LIM_RST;
      cfg_r.output_limit   <= OUT_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input handshake: taken only on the wait step
  assign in_ch.ready = (ctrl.jc == JC_IN);
  assign stat        = '{in_fire: in_ch.valid && in_ch.ready, out_free: out_free};

  ptpc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  ptpc_datapath #(
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .cfg           (cfg_r),
    .gain_clear    (gain_clear),
    .in_fire       (stat.in_fire),
    .sensor_word   (in_ch.sensor_word),
    .target_temp   (in_ch.target_temp),
    .out_ready     (out_ch.ready),
    .out_free      (out_free),
    .out_valid     (out_ch.valid),
    .measured_temp (out_ch.measured_temp),
    .duty_percent  (out_ch.duty_percent),
    .duty_count    (out_ch.duty_count)
  );

endmodule

`default_nettype wire
